// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the decoder.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ufd_pkg.sv -----
// Shared types and constants of the UTF-8 validating decoder.
// No dependencies; imported by the front, queue, back and checker modules.
`default_nettype none

package ufd_pkg;

  // Result status codes as seen on the output ports.
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_INV = 2'd1;
  localparam logic [1:0] STATUS_INC = 2'd2;

  localparam int unsigned CpW = 31;

  // What the back end does for one result.
  typedef enum logic [1:0] {
    OP_OK,     // value is final, status ok
    OP_CHECK,  // completed multi-byte value, check form and scalar rules
    OP_INV,    // invalid sequence
    OP_INC     // incomplete sequence
  } ufd_op_e;

  // One queue word: the results caused by one input byte.
  typedef struct packed {
    ufd_op_e          op0;
    logic [CpW-1:0]   val0;
    logic [2:0]       len0;
    logic             has1;
    ufd_op_e          op1;
    logic [6:0]       val1;
  } ufd_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ufd_front.sv -----
// Front end: accepts bytes, tracks the pending sequence and classifies results.
// Depends on ufd_pkg.
`default_nettype none

module ufd_front
  import ufd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_data_i,
  output ufd_entry_t      entry_o,
  output logic            push_o
);

  typedef struct packed {
    logic       emit;
    ufd_op_e    op;
    logic [6:0] val;
    logic       start;
    logic [2:0] len;
    logic [4:0] payload;
  } lead_t;

  function automatic lead_t take_lead(input logic [7:0] b, input logic eod);
    lead_t r;
    r = '0;
    r.op = OP_INV;
    if (!b[7]) begin
      r.emit = 1'b1;
      r.op   = OP_OK;
      r.val  = b[6:0];
    end else if (!b[6]) begin
      r.emit = 1'b1;
    end else if (!b[5]) begin
      r.start = 1'b1; r.len = 3'd2; r.payload = b[4:0];
    end else if (!b[4]) begin
      r.start = 1'b1; r.len = 3'd3; r.payload = {1'b0, b[3:0]};
    end else if (!b[3]) begin
      r.start = 1'b1; r.len = 3'd4; r.payload = {2'b0, b[2:0]};
    end else if (!b[2]) begin
      r.start = 1'b1; r.len = 3'd5; r.payload = {3'b0, b[1:0]};
    end else if (!b[1]) begin
      r.start = 1'b1; r.len = 3'd6; r.payload = {4'b0, b[0]};
    end else begin
      r.emit = 1'b1;
    end
    if (r.start && eod) begin
      r.start = 1'b0;
      r.emit  = 1'b1;
      r.op    = OP_INC;
    end
    return r;
  endfunction

  logic [CpW-1:0] acc_q, acc_d;
  logic [2:0]     rem_q, rem_d;
  logic [2:0]     len_q, len_d;
  lead_t          lead;
  logic [CpW-1:0] acc_next;
  logic           has_result;

  assign lead     = take_lead(data_byte_i, end_of_data_i);
  assign acc_next = {acc_q[CpW-7:0], data_byte_i[5:0]};

  always_comb begin
    acc_d      = acc_q;
    rem_d      = rem_q;
    len_d      = len_q;
    entry_o    = '0;
    has_result = 1'b0;
    if (rem_q == 3'd0) begin
      if (lead.emit) begin
        has_result   = 1'b1;
        entry_o.op0  = lead.op;
        entry_o.val0 = {{(CpW-7){1'b0}}, lead.val};
      end
      if (lead.start) begin
        acc_d = {{(CpW-5){1'b0}}, lead.payload};
        rem_d = lead.len - 3'd1;
        len_d = lead.len;
      end
    end else if (data_byte_i[7:6] == 2'b10) begin
      if (rem_q == 3'd1) begin
        has_result   = 1'b1;
        entry_o.op0  = OP_CHECK;
        entry_o.val0 = acc_next;
        entry_o.len0 = len_q;
        acc_d = '0; rem_d = '0; len_d = '0;
      end else if (end_of_data_i) begin
        has_result  = 1'b1;
        entry_o.op0 = OP_INC;
        acc_d = '0; rem_d = '0; len_d = '0;
      end else begin
        acc_d = acc_next;
        rem_d = rem_q - 3'd1;
      end
    end else begin
      // The breaking byte ends the old sequence and is then taken as a lead.
      has_result  = 1'b1;
      entry_o.op0 = (data_byte_i == 8'h00) ? OP_INC : OP_INV;
      acc_d = '0; rem_d = '0; len_d = '0;
      if (lead.emit) begin
        entry_o.has1 = 1'b1;
        entry_o.op1  = lead.op;
        entry_o.val1 = lead.val;
      end
      if (lead.start) begin
        acc_d = {{(CpW-5){1'b0}}, lead.payload};
        rem_d = lead.len - 3'd1;
        len_d = lead.len;
      end
    end
  end

  assign push_o = accept_i & has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= '0;
      len_q <= '0;
    end else if (accept_i) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ufd_queue.sv -----
// Small word queue between the front and back ends of the decoder.
// Depends on ufd_pkg for the queue word type.
`default_nettype none

module ufd_queue
  import ufd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  ufd_entry_t       wdata_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output ufd_entry_t       rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ufd_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ufd_back.sv -----
// Back end: checks completed values, splits words into results, output register.
// Depends on ufd_pkg.
`default_nettype none

module ufd_back
  import ufd_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_wdata_i,
  input  ufd_entry_t          head_i,
  input  wire logic           head_valid_i,
  output logic                head_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output logic [CpW-1:0]      code_point_o,
  output logic [1:0]          status_o,
  output logic                last_o
);

  function automatic logic [2:0] form_length(input logic [CpW-1:0] v);
    if (v < 31'h80)      return 3'd1;
    if (v < 31'h800)     return 3'd2;
    if (v < 31'h10000)   return 3'd3;
    if (v < 31'h200000)  return 3'd4;
    if (v < 31'h4000000) return 3'd5;
    return 3'd6;
  endfunction

  function automatic logic scalar_ok(input logic [CpW-1:0] v);
    if (v >= 31'h110000) return 1'b0;
    if ((v & 31'h7FFFF800) == 31'h0000D800) return 1'b0;
    if (v >= 31'hFDD0 && v <= 31'hFDEF) return 1'b0;
    if (v[15:1] == 15'h7FFF) return 1'b0;
    return 1'b1;
  endfunction

  logic           strict_q;
  logic           phase_q;
  logic           out_vld_q;
  logic [CpW-1:0] cp_q, cp_d;
  logic [1:0]     st_q, st_d;
  logic           last_q, last_d;
  ufd_op_e        cur_op;
  logic [CpW-1:0] cur_val;
  logic           load;

  assign cur_op  = phase_q ? head_i.op1 : head_i.op0;
  assign cur_val = phase_q ? {{(CpW-7){1'b0}}, head_i.val1} : head_i.val0;
  assign last_d  = phase_q | ~head_i.has1;

  always_comb begin
    cp_d = '0;
    st_d = STATUS_INV;
    unique case (cur_op)
      OP_OK: begin
        cp_d = cur_val;
        st_d = STATUS_OK;
      end
      OP_CHECK: begin
        if ((form_length(cur_val) == head_i.len0) && (!strict_q || scalar_ok(cur_val))) begin
          cp_d = cur_val;
          st_d = STATUS_OK;
        end
      end
      OP_INV: st_d = STATUS_INV;
      OP_INC: st_d = STATUS_INC;
      default: st_d = STATUS_INV;
    endcase
  end

  assign load       = head_valid_i & (~out_vld_q | pop_i);
  assign head_pop_o = load & last_d;
  assign empty_o    = ~out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q  <= 1'b1;
      phase_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        strict_q <= cfg_wdata_i;
      end
      if (load) begin
        phase_q   <= ~last_d;
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cp_d;
      st_q   <= st_d;
      last_q <= last_d;
    end
  end

  assign code_point_o = cp_q;
  assign status_o     = st_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_validating_decoder_top.sv -----
// Top level of the UTF-8 validating decoder: front end, word queue, back end.
// Depends on ufd_pkg, ufd_front, ufd_queue and ufd_back.
//
//   Channel   Direction  Handshake              Payload
//   input     in         push / full            data_byte_i, end_of_data_i
//   result    out        empty / pop            code_point_o, status_o, last_o
//   config    in         cfg_we_i               cfg_wdata_i (strict scalar checks)
//
// One byte is accepted per cycle while the queue is not full. A result passes through
// the queue and then the output register before it shows on the outputs.
// A byte that breaks a pending sequence and is itself a complete item yields two
// results, which leave the output register one after the other; the queue of
// QueueDepth words absorbs such bursts, and full rises only when it is filled.
// Reset clears the pending sequence, the queue and the output register and
// turns strict checking on. No clearing pass is needed after reset.
`default_nettype none

module utf8_validating_decoder_top
  import ufd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_data_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [30:0]      code_point_o,
  output logic [1:0]       status_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i
);

  // Words between front and back end: one per byte that causes any result.
  ufd_entry_t q_wdata, q_rdata;
  logic       q_push, q_full, q_pop, q_empty;
  logic       accept;

  // A byte is taken whenever the queue has room for the word it may create.
  assign accept = push & ~q_full;
  assign full   = q_full;

  ufd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .entry_o       (q_wdata),
    .push_o        (q_push)
  );

  ufd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // The back end turns each word into one or two results and applies the
  // range and noncharacter checks under the strict setting.
  ufd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_i       (q_rdata),
    .head_valid_i (~q_empty),
    .head_pop_o   (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .code_point_o (code_point_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ufd_checker.sv -----
// Port-level checker for the UTF-8 validating decoder, bound to the top level.
// Depends on ufd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ufd_checker
  import ufd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [30:0] code_point_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_o
);

  `ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty, "results shown during reset")
  `ASSERT_RST(a_status_code, clk_i, rst_ni, !empty |-> (status_o == STATUS_OK || status_o == STATUS_INV || status_o == STATUS_INC), "unknown status code")
  `ASSERT_RST(a_zero_on_error, clk_i, rst_ni, (!empty && status_o != STATUS_OK) |-> (code_point_o == '0), "nonzero code point on error")
  `ASSERT_RST(a_hold_stalled, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(code_point_o) && $stable(status_o) && $stable(last_o)), "stalled result changed")

endmodule

bind utf8_validating_decoder_top ufd_checker u_ufd_checker (.*);

`default_nettype wire

// ----- test/utf8_decode_checker.sv -----
`timescale 1ns / 1ps
// Checker for the UTF-8 validating decoder: watches the byte, result and config channels,
// predicts every result and compares it field by field. Depends on ufd_pkg.
module utf8_decode_checker
  import ufd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_data_i,
  input  wire logic        pop_i,
  input  wire logic        empty_i,
  input  wire logic [30:0] code_point_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        last_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct {
    logic [30:0] cp;
    logic [1:0]  st;
    logic        lst;
  } decoded_t;

  decoded_t    expected_cp_q[$];
  decoded_t    step_res[$];
  logic [30:0] acc;
  logic [2:0]  cont_left;
  logic [2:0]  seq_len;
  logic        strict_mode;

  function automatic logic [2:0] shortest_len(input logic [30:0] v);
    if (v < 31'h80) return 3'd1;
    if (v < 31'h800) return 3'd2;
    if (v < 31'h10000) return 3'd3;
    if (v < 31'h200000) return 3'd4;
    if (v < 31'h4000000) return 3'd5;
    return 3'd6;
  endfunction

  // Unicode scalar range, surrogates and noncharacters.
  function automatic logic is_scalar(input logic [30:0] v);
    if (v >= 31'h110000) return 1'b0;
    if ((v & 31'h7FFFF800) == 31'hD800) return 1'b0;
    if (v >= 31'hFDD0 && v <= 31'hFDEF) return 1'b0;
    if ((v & 31'hFFFE) == 31'hFFFE) return 1'b0;
    return 1'b1;
  endfunction

  task automatic add_result(input logic [30:0] cp, input logic [1:0] st);
    decoded_t r;
    r.cp  = cp;
    r.st  = st;
    r.lst = 1'b0;
    step_res.push_back(r);
  endtask

  task automatic drop_sequence();
    acc       = '0;
    cont_left = '0;
    seq_len   = '0;
  endtask

  task automatic decode_lead(input logic [7:0] b, input logic eod);
    logic [2:0]  len;
    logic [30:0] payload;
    len     = '0;
    payload = '0;
    if (b < 8'h80) begin
      add_result({23'd0, b}, STATUS_OK);
    end else if (b < 8'hC0 || b >= 8'hFE) begin
      add_result('0, STATUS_INV);
    end else begin
      if (b < 8'hE0) begin
        len = 3'd2; payload = {26'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        len = 3'd3; payload = {27'd0, b[3:0]};
      end else if (b < 8'hF8) begin
        len = 3'd4; payload = {28'd0, b[2:0]};
      end else if (b < 8'hFC) begin
        len = 3'd5; payload = {29'd0, b[1:0]};
      end else begin
        len = 3'd6; payload = {30'd0, b[0]};
      end
      if (eod) begin
        drop_sequence();
        add_result('0, STATUS_INC);
      end else begin
        acc       = payload;
        cont_left = len - 3'd1;
        seq_len   = len;
      end
    end
  endtask

  // Runs one accepted byte through the predictor and queues the results it causes.
  task automatic decode_byte(input logic [7:0] b, input logic eod);
    logic [30:0] v;
    logic        good;
    step_res.delete();
    if (cont_left == 0) begin
      decode_lead(b, eod);
    end else if (b[7:6] == 2'b10) begin
      acc       = {acc[24:0], b[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == 0) begin
        v    = acc;
        good = (shortest_len(v) == seq_len);
        if (good && strict_mode) good = is_scalar(v);
        drop_sequence();
        if (good) add_result(v, STATUS_OK);
        else add_result('0, STATUS_INV);
      end else if (eod) begin
        drop_sequence();
        add_result('0, STATUS_INC);
      end
    end else begin
      // The byte broke the pending sequence; it is then decoded again as a lead byte.
      drop_sequence();
      add_result('0, (b == 8'h00) ? STATUS_INC : STATUS_INV);
      decode_lead(b, eod);
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].lst = 1'b1;
    foreach (step_res[i]) expected_cp_q.push_back(step_res[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      expected_cp_q.delete();
      drop_sequence();
      strict_mode = 1'b1;
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      // A result never leaves in the cycle its byte enters, so compare first.
      if (pop_i && !empty_i) begin
        if (expected_cp_q.size() == 0) begin
          $error("unexpected word: code_point %h, status %0d", code_point_i, status_i);
          errors_o++;
        end else begin
          want = expected_cp_q.pop_front();
          if (code_point_i !== want.cp) begin
            $error("code_point: expected %h, got %h", want.cp, code_point_i);
            errors_o++;
          end
          if (status_i !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status_i);
            errors_o++;
          end
          if (last_i !== want.lst) begin
            $error("last: expected %0d, got %0d", want.lst, last_i);
            errors_o++;
          end
        end
      end
      if (push_i && !full_i) decode_byte(data_byte_i, end_of_data_i);
      if (cfg_we_i) strict_mode = cfg_wdata_i;
      pending_o = expected_cp_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and the verdict.
// Depends on utf8_validating_decoder_top and utf8_decode_checker.
module tb;

  localparam int CycleLimit = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        end_of_data;
  logic        empty;
  logic        pop = 1'b0;
  logic [30:0] code_point;
  logic [1:0]  status;
  logic        last;
  logic        cfg_we;
  logic        cfg_wdata;
  int          errors;
  int          pending;
  int          cycles;
  int          idle_pct;
  int          stall_pct;
  int          sent_bytes;

  // Smallest and largest value that each sequence length can carry without being overlong.
  logic [30:0] len_min [1:6];
  logic [30:0] len_max [1:6];

  utf8_validating_decoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .end_of_data_i (end_of_data),
    .empty         (empty),
    .pop           (pop),
    .code_point_o  (code_point),
    .status_o      (status),
    .last_o        (last),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  utf8_decode_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .data_byte_i   (data_byte),
    .end_of_data_i (end_of_data),
    .pop_i         (pop),
    .empty_i       (empty),
    .code_point_i  (code_point),
    .status_i      (status),
    .last_i        (last),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver drops pop at random, as often as the current phase asks.
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // A run that hangs is cut off here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Offers one byte after a random number of idle cycles and returns at the falling
  // edge after the word has been taken.
  task automatic send_byte(input logic [7:0] b, input logic eod);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    data_byte   <= b;
    end_of_data <= eod;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  // Stops sending until every expected word has come out, then lets the pipeline settle.
  task automatic drain();
    push <= 1'b0;
    wait (pending == 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_strict(input logic value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Byte idx of the len-byte encoding of cp; byte 0 is the lead.
  function automatic logic [7:0] utf8_byte(input logic [30:0] cp, input int len, input int idx);
    logic [30:0] part;
    part = cp >> (6 * (len - 1 - idx));
    if (idx != 0) return {2'b10, part[5:0]};
    case (len)
      1: return {1'b0, part[6:0]};
      2: return {3'b110, part[4:0]};
      3: return {4'b1110, part[3:0]};
      4: return {5'b11110, part[2:0]};
      5: return {6'b111110, part[1:0]};
      default: return {7'b1111110, part[0]};
    endcase
  endfunction

  // Sends the first count bytes of an encoding. An occasional end-of-data mark falls on
  // any byte; eod_last forces it on the final one.
  task automatic send_encoded(input logic [30:0] cp, input int len, input int count,
                              input logic eod_last);
    logic eod;
    for (int i = 0; i < count; i++) begin
      eod = ($urandom_range(0, 39) == 0) || (eod_last && i == count - 1);
      send_byte(utf8_byte(cp, len, i), eod);
    end
  endtask

  // One random chunk of stream: mostly well-formed sequences, some overlong forms,
  // sequences cut short by a breaking byte or end of data, and raw noise.
  task automatic send_random_chunk();
    int          kind;
    int          len;
    int          cut;
    logic [30:0] cp;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 6);
    cp   = 31'($urandom_range(len_min[len], len_max[len]));
    if (kind < 60) begin
      // Values near the scalar and noncharacter limits, encoded at their natural length.
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: cp = 31'(31'hD800 + $urandom_range(0, 31'h7FF));
          1: cp = 31'(31'hFDD0 + $urandom_range(0, 31'h1F));
          2: cp = 31'({$urandom_range(0, 16), 15'h7FFF, 1'($urandom_range(0, 1))}
                      & 31'h1FFFFF);
          3: cp = 31'h10FFFF;
          4: cp = 31'(31'h110000 + $urandom_range(0, 15));
          default: cp = $urandom_range(0, 1) ? 31'hFDCF : 31'hFDF0;
        endcase
        for (len = 1; len < 6 && cp > len_max[len]; len++) ;
      end
      send_encoded(cp, len, len, 1'b0);
    end else if (kind < 70) begin
      len = $urandom_range(2, 6);
      cp  = 31'($urandom_range(0, len_min[len] - 1));
      send_encoded(cp, len, len, 1'b0);
    end else if (kind < 85) begin
      len = $urandom_range(2, 6);
      cp  = 31'($urandom_range(len_min[len], len_max[len]));
      cut = $urandom_range(1, len - 1);
      case ($urandom_range(0, 4))
        0: send_encoded(cp, len, cut, 1'b1);
        1: begin
          send_encoded(cp, len, cut, 1'b0);
          send_byte(8'h00, $urandom_range(0, 3) == 0);
        end
        2: begin
          send_encoded(cp, len, cut, 1'b0);
          send_byte(8'($urandom_range(1, 8'h7F)), 1'b0);
        end
        3: begin
          send_encoded(cp, len, cut, 1'b0);
          send_byte(8'($urandom_range(8'hC0, 8'hFD)), $urandom_range(0, 5) == 0);
        end
        default: begin
          send_encoded(cp, len, cut, 1'b0);
          send_byte(8'($urandom_range(8'hFE, 8'hFF)), 1'b0);
        end
      endcase
    end else begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    int phase_bytes;
    len_min[1] = 31'h0;       len_max[1] = 31'h7F;
    len_min[2] = 31'h80;      len_max[2] = 31'h7FF;
    len_min[3] = 31'h800;     len_max[3] = 31'hFFFF;
    len_min[4] = 31'h10000;   len_max[4] = 31'h1FFFFF;
    len_min[5] = 31'h200000;  len_max[5] = 31'h3FFFFFF;
    len_min[6] = 31'h4000000; len_max[6] = 31'h7FFFFFFF;
    cycles      = 0;
    sent_bytes  = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    rst_ni      = 1'b0;
    push        = 1'b0;
    data_byte   = 8'h00;
    end_of_data = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed bytes with strict checking on, as it is after reset. NUL and DEL when idle,
    // a stray continuation, the two forbidden leads, a two-byte character, an overlong
    // NUL, a sequence broken by NUL (incomplete, then NUL itself), a value just above the
    // Unicode range, a sequence broken by ASCII, end of data on a lead byte, and the
    // largest six-byte value.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE0, 1'b1);
    send_byte(8'hFD, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);

    // Four phases of random stream; strict checking alternates between off and on.
    for (int ph = 0; ph < 4; ph++) begin
      write_strict(ph[0]);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 275) begin
        // Halfway through the stalling phase, let the result side empty completely.
        if (ph == 2 && phase_bytes >= 137 && phase_bytes < 145) begin
          drain();
          phase_bytes = 145;
        end
        sent_bytes = 0;
        send_random_chunk();
        phase_bytes += sent_bytes;
      end
    end

    push <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ufd_pkg.sv
hw/rtl/ufd_front.sv
hw/rtl/ufd_queue.sv
hw/rtl/ufd_back.sv
hw/rtl/utf8_validating_decoder_top.sv
hw/rtl/ufd_checker.sv
test/utf8_decode_checker.sv
test/tb.sv
